>>> rtl/rafc_pkg.sv
// shared types, codes and constants of the radio api frame codec
package rafc_pkg;

    // default sizes
    localparam int PAYLOAD_BYTES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // frame bytes
    localparam logic [7:0]  DELIM         = 8'h7E;
    localparam logic [7:0]  TYPE_RXPKT    = 8'h90;
    localparam logic [7:0]  TYPE_STATUS   = 8'h8B;
    localparam logic [7:0]  TYPE_TXREQ    = 8'h10;
    localparam logic [7:0]  DELIV_OK      = 8'h00;
    localparam logic [7:0]  DELIV_NOROUTE = 8'h25;
    localparam logic [15:0] RX_HEADER_LEN = 16'd12;
    localparam int          TX_HEADER_BYTES = 17;

    // result kinds
    localparam logic [2:0] KIND_TX_LINE    = 3'd0;
    localparam logic [2:0] KIND_RX_BYTE    = 3'd1;
    localparam logic [2:0] KIND_RX_END     = 3'd2;
    localparam logic [2:0] KIND_STATUS_END = 3'd3;
    localparam logic [2:0] KIND_DROP       = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_IDENT     = 3'd0;
    localparam logic [2:0] CFG_DEST_ADDR_LONG  = 3'd1;
    localparam logic [2:0] CFG_DEST_ADDR_SHORT = 3'd2;
    localparam logic [2:0] CFG_HOP_RADIUS      = 3'd3;
    localparam logic [2:0] CFG_SEND_OPTIONS    = 3'd4;

    // transmit burst steps, header first then payload and checksum
    localparam logic [4:0] STEP_DELIM      = 5'd0;
    localparam logic [4:0] STEP_LEN_HI     = 5'd1;
    localparam logic [4:0] STEP_LEN_LO     = 5'd2;
    localparam logic [4:0] STEP_TYPE       = 5'd3;
    localparam logic [4:0] STEP_IDENT      = 5'd4;
    localparam logic [4:0] STEP_LONG_FIRST = 5'd5;
    localparam logic [4:0] STEP_LONG_LAST  = 5'd12;
    localparam logic [4:0] STEP_SHORT_HI   = 5'd13;
    localparam logic [4:0] STEP_SHORT_LO   = 5'd14;
    localparam logic [4:0] STEP_RADIUS     = 5'd15;
    localparam logic [4:0] STEP_OPTIONS    = 5'd16;
    localparam logic [4:0] STEP_PAYLOAD    = 5'd17;
    localparam logic [4:0] STEP_CHECK      = 5'd18;

    // receive parser phases
    typedef enum logic [3:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_SRC_LONG, PH_SRC_SHORT,
        PH_OPTS, PH_PAYLOAD, PH_RX_CK, PH_ST_ID, PH_ST_ADDR, PH_ST_RETRY,
        PH_ST_DELIV, PH_ST_DISC, PH_ST_CK
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [15:0] byte_index;
        logic        run_last;
        logic [63:0] source_long;
        logic [15:0] source_short;
        logic [7:0]  recv_options;
        logic [7:0]  retries;
        logic [7:0]  delivery_code;
        logic [7:0]  discovery_code;
        logic        delivered;
    } t_result;

    typedef struct packed {
        logic [7:0] retries;
        logic [7:0] delivery;
        logic [7:0] discovery;
    } t_status;

    // one classified request handed from front to back
    typedef struct packed {
        logic        is_tx;
        logic        hdr;
        logic        ck;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [63:0] src_long;
        logic [15:0] src_short;
        logic [7:0]  opts;
        t_status     status;
        logic        delivered;
    } t_job;

    typedef struct packed {
        logic [7:0]  frame_ident;
        logic [63:0] dest_addr_long;
        logic [15:0] dest_addr_short;
        logic [7:0]  hop_radius;
        logic [7:0]  send_options;
    } t_cfg;

endpackage

>>> rtl/rafc_front.sv
// front end: receive parser, transmit counter and status, classifies each request
module rafc_front #(
    parameter int PAYLOAD_BYTES = rafc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rafc_pkg::t_item  i_item,
    output logic             o_job_valid,
    output rafc_pkg::t_job   o_job
);
    import rafc_pkg::*;

    localparam int TXW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [TXW-1:0] TX_LAST = TXW'(PAYLOAD_BYTES - 1);

    t_phase         r_phase, n_phase;
    logic [15:0]    r_length, n_length;
    logic [15:0]    r_count, n_count;
    logic [63:0]    r_src_long, n_src_long;
    logic [15:0]    r_src_short, n_src_short;
    logic [7:0]     r_opts, n_opts;
    t_status        r_status, n_status;
    logic [TXW-1:0] r_tx_count, n_tx_count;

    logic [15:0] count_inc;
    logic [7:0]  b;

    assign b         = i_item.data_byte;
    assign count_inc = r_count + 16'd1;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_length    <= '0;
            r_count     <= '0;
            r_src_long  <= '0;
            r_src_short <= '0;
            r_opts      <= '0;
            r_status    <= '0;
            r_tx_count  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_count     <= n_count;
            r_src_long  <= n_src_long;
            r_src_short <= n_src_short;
            r_opts      <= n_opts;
            r_status    <= n_status;
            r_tx_count  <= n_tx_count;
        end
    end

    // next state and job classification
    always_comb begin
        n_phase     = r_phase;
        n_length    = r_length;
        n_count     = r_count;
        n_src_long  = r_src_long;
        n_src_short = r_src_short;
        n_opts      = r_opts;
        n_status    = r_status;
        n_tx_count  = r_tx_count;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job.status = r_status;
        o_job.data   = b;

        if (i_valid) begin
            if (i_item.cmd) begin
                // transmit payload byte
                o_job_valid = 1'b1;
                o_job.is_tx = 1'b1;
                o_job.hdr   = (r_tx_count == '0);
                o_job.ck    = (r_tx_count == TX_LAST);
                if (r_tx_count == TX_LAST) begin
                    n_tx_count = '0;
                    o_job.delivered = (r_status.delivery == DELIV_OK);
                    if (r_status.delivery == DELIV_OK) begin
                        n_status.delivery = DELIV_NOROUTE;
                    end
                end else begin
                    n_tx_count = r_tx_count + TXW'(1);
                end
            end else begin
                // receive link byte
                unique case (r_phase)
                    PH_HUNT: begin
                        if (b == DELIM) begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_length = {b, 8'h00};
                        n_phase  = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_length = r_length | {8'h00, b};
                        n_phase  = PH_TYPE;
                    end
                    PH_TYPE: begin
                        n_count = '0;
                        if (b == TYPE_RXPKT) begin
                            n_src_long = '0;
                            n_phase    = PH_SRC_LONG;
                        end else if (b == TYPE_STATUS) begin
                            n_phase = PH_ST_ID;
                        end else begin
                            o_job_valid = 1'b1;
                            o_job.kind  = KIND_DROP;
                            n_phase     = PH_HUNT;
                        end
                    end
                    PH_SRC_LONG: begin
                        n_src_long = {r_src_long[55:0], b};
                        n_count    = count_inc;
                        if (count_inc >= 16'd8) begin
                            n_count     = '0;
                            n_src_short = '0;
                            n_phase     = PH_SRC_SHORT;
                        end
                    end
                    PH_SRC_SHORT: begin
                        n_src_short = {r_src_short[7:0], b};
                        n_count     = count_inc;
                        if (count_inc >= 16'd2) begin
                            n_phase = PH_OPTS;
                        end
                    end
                    PH_OPTS: begin
                        n_opts  = b;
                        n_count = '0;
                        n_phase = (r_length > RX_HEADER_LEN) ? PH_PAYLOAD : PH_RX_CK;
                    end
                    PH_PAYLOAD: begin
                        o_job_valid = 1'b1;
                        o_job.kind  = KIND_RX_BYTE;
                        o_job.index = r_count;
                        n_count     = count_inc;
                        if (count_inc >= (r_length - RX_HEADER_LEN)) begin
                            n_phase = PH_RX_CK;
                        end
                    end
                    PH_RX_CK: begin
                        o_job_valid     = 1'b1;
                        o_job.kind      = KIND_RX_END;
                        o_job.data      = '0;
                        o_job.src_long  = r_src_long;
                        o_job.src_short = r_src_short;
                        o_job.opts      = r_opts;
                        n_phase         = PH_HUNT;
                    end
                    PH_ST_ID: begin
                        n_count = '0;
                        n_phase = PH_ST_ADDR;
                    end
                    PH_ST_ADDR: begin
                        n_count = count_inc;
                        if (count_inc >= 16'd2) begin
                            n_phase = PH_ST_RETRY;
                        end
                    end
                    PH_ST_RETRY: begin
                        n_status.retries = b;
                        n_phase = PH_ST_DELIV;
                    end
                    PH_ST_DELIV: begin
                        n_status.delivery = b;
                        n_phase = PH_ST_DISC;
                    end
                    PH_ST_DISC: begin
                        n_status.discovery = b;
                        n_phase = PH_ST_CK;
                    end
                    PH_ST_CK: begin
                        o_job_valid = 1'b1;
                        o_job.kind  = KIND_STATUS_END;
                        o_job.data  = '0;
                        n_phase     = PH_HUNT;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/rafc_queue.sv
// short request queue between front and back ends
module rafc_queue #(
    parameter int DEPTH = rafc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rafc_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_head_valid,
    output rafc_pkg::t_job  o_head,
    input  logic            i_pop
);
    import rafc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/rafc_back.sv
// back end: expands requests into result items, builds transmit frames
module rafc_back #(
    parameter int PAYLOAD_BYTES = rafc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rafc_pkg::t_cfg    i_cfg,
    input  logic              i_head_valid,
    input  rafc_pkg::t_job    i_head,
    output logic              o_head_pop,
    output rafc_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import rafc_pkg::*;

    localparam logic [15:0] TX_LEN = 16'(PAYLOAD_BYTES + TX_HEADER_BYTES + 1 - 4);

    logic [4:0] r_step;
    logic [7:0] r_sum;
    t_result    r_out;
    logic       r_out_valid;

    logic [4:0] step;
    logic       take, last;
    logic [7:0] tx_byte;
    logic [2:0] long_sel;
    t_result    res;

    // effective step of the head request
    assign step     = i_head.hdr ? r_step : r_step + STEP_PAYLOAD;
    assign last     = !i_head.is_tx || (i_head.ck ? (step == STEP_CHECK)
                                                  : (step == STEP_PAYLOAD));
    assign take     = i_head_valid && (!r_out_valid || i_pop);
    assign o_head_pop = take && last;
    assign long_sel = 3'(STEP_LONG_LAST - step);

    // transmit line byte for this step
    always_comb begin
        unique case (step) inside
            STEP_DELIM:      tx_byte = DELIM;
            STEP_LEN_HI:     tx_byte = TX_LEN[15:8];
            STEP_LEN_LO:     tx_byte = TX_LEN[7:0];
            STEP_TYPE:       tx_byte = TYPE_TXREQ;
            STEP_IDENT:      tx_byte = i_cfg.frame_ident;
            [STEP_LONG_FIRST:STEP_LONG_LAST]:
                             tx_byte = i_cfg.dest_addr_long[{long_sel, 3'b000} +: 8];
            STEP_SHORT_HI:   tx_byte = i_cfg.dest_addr_short[15:8];
            STEP_SHORT_LO:   tx_byte = i_cfg.dest_addr_short[7:0];
            STEP_RADIUS:     tx_byte = i_cfg.hop_radius;
            STEP_OPTIONS:    tx_byte = i_cfg.send_options;
            STEP_PAYLOAD:    tx_byte = i_head.data;
            STEP_CHECK:      tx_byte = ~r_sum;
            default:         tx_byte = '0;
        endcase
    end

    // result item of this step
    always_comb begin
        res                = '0;
        res.run_last       = last;
        res.retries        = i_head.status.retries;
        res.delivery_code  = i_head.status.delivery;
        res.discovery_code = i_head.status.discovery;
        if (i_head.is_tx) begin
            res.out_kind  = KIND_TX_LINE;
            res.out_byte  = tx_byte;
            res.delivered = (step == STEP_CHECK) && i_head.delivered;
        end else begin
            res.out_kind     = i_head.kind;
            res.out_byte     = i_head.data;
            res.byte_index   = i_head.index;
            res.source_long  = i_head.src_long;
            res.source_short = i_head.src_short;
            res.recv_options = i_head.opts;
        end
    end

    // step counter and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_sum  <= '0;
        end else if (take) begin
            r_step <= last ? '0 : r_step + 5'd1;
            if (i_head.is_tx) begin
                if (step == STEP_DELIM || step == STEP_CHECK) begin
                    r_sum <= '0;
                end else if (step >= STEP_TYPE) begin
                    r_sum <= r_sum + tx_byte;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    // step never runs past the checksum
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_CHECK)
        else $error("burst step out of range");

    // receive requests give a single result
    a_rx_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid && !i_head.is_tx |-> r_step == '0)
        else $error("receive request mid burst");

    // a delivered flag only on the closing line byte of a request
    a_delivered_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.delivered |-> r_out.run_last
            && r_out.out_kind == KIND_TX_LINE)
        else $error("delivered flag outside checksum byte");

endmodule

>>> rtl/radio_api_frame_codec_unit.sv
// top level of the radio api frame codec: config registers, front, queue and back
//
//  channel   direction  handshake            payload
//  input     in         push / full          i_item (cmd, data_byte)
//  result    out        empty / pop          o_result (out_kind .. delivered)
//  config    in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// every input request is taken while the request queue has room; results leave
// one per cycle while pop is held; a first transmit payload byte gives 18 results
// and the last one a checksum byte too, so the back end sets the drain rate.
// synchronous active-low reset; no clearing pass, ready in the cycle after.
// either side may stall: the queue and the output register decouple them.
module radio_api_frame_codec_unit #(
    parameter int PAYLOAD_BYTES = rafc_pkg::PAYLOAD_BYTES_DEF,
    parameter int QUEUE_DEPTH   = rafc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rafc_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output rafc_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);
    import rafc_pkg::*;

    t_cfg r_cfg;
    logic accept, job_valid, head_valid, head_pop;
    t_job job, head;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_IDENT:     r_cfg.frame_ident     <= i_cfg_data[7:0];
                CFG_DEST_ADDR_LONG:  r_cfg.dest_addr_long  <= i_cfg_data;
                CFG_DEST_ADDR_SHORT: r_cfg.dest_addr_short <= i_cfg_data[15:0];
                CFG_HOP_RADIUS:      r_cfg.hop_radius      <= i_cfg_data[7:0];
                CFG_SEND_OPTIONS:    r_cfg.send_options    <= i_cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    rafc_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    rafc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (job_valid),
        .i_job        (job),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (head_pop)
    );

    rafc_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule
